// File: sv/als_pkg.sv
// shared constants and types for the adc level scrolling bar display
// no dependencies; imported by every module of the block
package als_pkg;

    localparam int BLOCK_LEN  = 64;
    localparam int SAMPLE_W   = 8;
    localparam int ROW_CNT    = 8;
    localparam int ROW_W      = $clog2(ROW_CNT);
    localparam int PIX_W      = 8;
    localparam int WORD_W     = PIX_W + ROW_CNT;
    localparam int LEVEL_CNT  = 8;
    localparam int LEVEL_W    = $clog2(LEVEL_CNT);
    // one level step of the mean is 256 / 8 = 32 codes
    localparam int MEAN_STEP  = (1 << SAMPLE_W) / LEVEL_CNT;
    localparam int LEVEL_STEP = MEAN_STEP * BLOCK_LEN;
    localparam int SUM_MAX    = ((1 << SAMPLE_W) - 1) * BLOCK_LEN;
    localparam int SUM_W      = $clog2(SUM_MAX + 1);
    localparam int CNT_W      = $clog2(BLOCK_LEN);

    typedef struct packed {
        logic               en;
        logic [PIX_W-1:0]   col;
    } t_scroll;

endpackage

// File: sv/als_accum.sv
// block accumulator: sums samples, finds the level at block end
// depends on als_pkg; drives the scroll request into the row chain
module als_accum (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic [als_pkg::SAMPLE_W-1:0]  i_sample,
    output als_pkg::t_scroll              o_scroll
);
    import als_pkg::*;

    logic [SUM_W-1:0]   r_sum, n_sum, sum_add;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               last;
    logic [LEVEL_W-1:0] level;

    assign sum_add = r_sum + SUM_W'(i_sample);
    assign last    = (r_cnt == CNT_W'(BLOCK_LEN - 1));

    // floor(mean / 32) equals floor(sum / (32 * block length)): count thresholds
    always_comb begin
        level = '0;
        for (int k = 1; k < LEVEL_CNT; k++) begin
            if (sum_add >= SUM_W'(k * LEVEL_STEP)) begin
                level = LEVEL_W'(k);
            end
        end
    end

    always_comb begin
        n_sum = r_sum;
        n_cnt = r_cnt;
        if (i_take) begin
            if (last) begin
                n_sum = '0;
                n_cnt = '0;
            end else begin
                n_sum = sum_add;
                n_cnt = r_cnt + CNT_W'(1);
            end
        end
    end

    assign o_scroll.en  = i_take & last;
    assign o_scroll.col = PIX_W'(1) << level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else begin
            r_sum <= n_sum;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: sv/als_row_cell.sv
// one display row cell: holds a row and takes its neighbor's row on scroll
// depends on als_pkg
module als_row_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_shift,
    input  logic [als_pkg::PIX_W-1:0]  i_row,
    output logic [als_pkg::PIX_W-1:0]  o_row
);
    import als_pkg::*;

    logic [PIX_W-1:0] r_row, n_row;

    assign n_row = i_shift ? i_row : r_row;
    assign o_row = r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

endmodule

// File: sv/adc_level_scrolling_bar_display.sv
// adc level scrolling bar display, top level
// input channel: i_in_valid / o_in_stall with i_mode and i_sample; an item
// is accepted at a clock edge with i_in_valid high and o_in_stall low.
// output channel: o_out_valid / i_out_stall with o_scan_word.
// a sample item (mode 0) is added to the running block sum and gives no
// output; every 64th sample closes the block, and the row chain scrolls
// down one cell with the new one-hot level column entering row 0.
// a refresh tick (mode 1) gives one scan word: current row pixels in the
// upper byte, one-hot row select in the lower byte, then the row pointer
// advances modulo 8.
// the scan word is registered and appears in the cycle after its tick is accepted.
// throughput: one item per cycle; the single output register is refilled
// in the same cycle it is taken, so o_in_stall is high only while a word
// waits in the output register and i_out_stall holds it there.
// reset (synchronous, i_rst_n low) clears the sum, count, all rows, the
// row pointer and the output valid.
// depends on als_pkg, als_accum and als_row_cell
module adc_level_scrolling_bar_display (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [als_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [als_pkg::WORD_W-1:0]    o_scan_word
);
    import als_pkg::*;

    logic             take, take_sample, take_tick;
    t_scroll          scroll;
    logic [PIX_W-1:0] rows [ROW_CNT];
    logic [PIX_W-1:0] row_in [ROW_CNT];

    logic [ROW_W-1:0]  r_scan_row, n_scan_row;
    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_word, n_word;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign take        = i_in_valid & ~o_in_stall;
    assign take_sample = take & ~i_mode;
    assign take_tick   = take & i_mode;

    als_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take_sample),
        .i_sample (i_sample),
        .o_scroll (scroll)
    );

    // row 0 takes the new column, every other cell its upper neighbor
    always_comb begin
        row_in[0] = scroll.col;
        for (int i = 1; i < ROW_CNT; i++) begin
            row_in[i] = rows[i-1];
        end
    end

    for (genvar g = 0; g < ROW_CNT; g++) begin : g_row
        als_row_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (scroll.en),
            .i_row   (row_in[g]),
            .o_row   (rows[g])
        );
    end

    always_comb begin
        n_scan_row  = r_scan_row;
        n_out_valid = r_out_valid & i_out_stall;
        n_word      = r_word;
        if (take_tick) begin
            n_scan_row  = r_scan_row + ROW_W'(1);
            n_out_valid = 1'b1;
            n_word      = {rows[r_scan_row], ROW_CNT'(1) << r_scan_row};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_row  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_scan_row  <= n_scan_row;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_scan_word = r_word;

endmodule

// File: tb/adc_level_scrolling_bar_display_tb.sv
`timescale 1ns / 1ps
// testbench for adc_level_scrolling_bar_display: a scan-word scoreboard that mirrors
// the block sums and row scroll, plus random item and stall traffic on both channels
// depends on als_pkg and the adc_level_scrolling_bar_display rtl
module adc_level_scrolling_bar_display_tb;
    import als_pkg::*;

    localparam int LEVEL_SHIFT = SAMPLE_W - LEVEL_W;
    localparam int ITEM_TARGET = 700;
    localparam int CYCLE_LIMIT = 500000;

    typedef enum int {
        PAT_CONST,
        PAT_PAIRS,
        PAT_PAIRS_LOW,
        PAT_NOISE
    } t_block_pat;

    class scan_scoreboard;
        logic [SUM_W-1:0]   block_sum;
        logic [CNT_W-1:0]   block_count;
        logic [PIX_W-1:0]   rows [ROW_CNT];
        logic [ROW_W-1:0]   scan_row;
        logic [WORD_W-1:0]  expected_words [$];
        int                 errors;
        int                 words_checked;
        int                 samples_seen;
        int                 blocks_closed;
        logic [LEVEL_CNT-1:0] levels_seen;

        function new();
            block_sum = '0;
            block_count = '0;
            foreach (rows[i]) rows[i] = '0;
            scan_row = '0;
            errors = 0;
            words_checked = 0;
            samples_seen = 0;
            blocks_closed = 0;
            levels_seen = '0;
        endfunction

        function void note_item(logic mode, logic [SAMPLE_W-1:0] sample);
            logic [SAMPLE_W-1:0] mean;
            logic [LEVEL_W-1:0]  level;
            logic [ROW_CNT-1:0]  sel;
            if (mode) begin
                sel = '0;
                sel[scan_row] = 1'b1;
                expected_words.push_back({rows[scan_row], sel});
                scan_row = scan_row + 1'b1;
                return;
            end
            samples_seen++;
            block_sum = block_sum + sample;
            if (block_count == CNT_W'(BLOCK_LEN - 1)) begin
                mean = SAMPLE_W'(block_sum / BLOCK_LEN);
                level = LEVEL_W'(mean >> LEVEL_SHIFT);
                // shift first, then load row 0, so the new column lands in row 0 only
                for (int i = ROW_CNT - 1; i > 0; i--) rows[i] = rows[i-1];
                rows[0] = PIX_W'(1) << level;
                levels_seen[level] = 1'b1;
                blocks_closed++;
                block_sum = '0;
                block_count = '0;
            end else begin
                block_count = block_count + 1'b1;
            end
        endfunction

        function void check_word(logic [WORD_W-1:0] word);
            logic [WORD_W-1:0] exp_word;
            if (expected_words.size() == 0) begin
                $display("%0t: scan word %h with none expected", $time, word);
                errors++;
                return;
            end
            exp_word = expected_words.pop_front();
            words_checked++;
            if (word !== exp_word) begin
                $display("%0t: scan_word mismatch expected %h actual %h",
                         $time, exp_word, word);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_mode = 1'b0;
    logic [SAMPLE_W-1:0]  i_sample = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [WORD_W-1:0]    o_scan_word;

    scan_scoreboard sb = new();
    int items_sent = 0;
    int ticks_sent = 0;
    int cycles = 0;
    int stall_left = 0;
    int stall_pct = 0;
    int regime_left = 0;

    adc_level_scrolling_bar_display i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_scan_word (o_scan_word)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic drive_item(logic mode, logic [SAMPLE_W-1:0] sample, bit no_gap);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_sample <= sample;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_item(mode, sample);
        items_sent++;
        if (mode) ticks_sent++;
    endtask

    task automatic drain_words();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_block(int level, t_block_pat pat, bit no_gap);
        logic [SAMPLE_W-1:0] vals [BLOCK_LEN];
        int m;
        int d_max;
        int d;
        m = level * MEAN_STEP;
        case ($urandom_range(0, 2))
            0: m = level * MEAN_STEP;
            1: m = level * MEAN_STEP + MEAN_STEP - 1;
            default: m = level * MEAN_STEP + $urandom_range(0, MEAN_STEP - 1);
        endcase
        if (pat == PAT_PAIRS_LOW) m = level * MEAN_STEP;
        d_max = (m < 255 - m) ? m : 255 - m;
        for (int k = 0; k < BLOCK_LEN; k += 2) begin
            d = $urandom_range(0, d_max);
            case (pat)
                PAT_CONST: begin
                    vals[k] = SAMPLE_W'(m);
                    vals[k+1] = SAMPLE_W'(m);
                end
                PAT_NOISE: begin
                    vals[k] = SAMPLE_W'($urandom);
                    vals[k+1] = SAMPLE_W'($urandom);
                end
                default: begin
                    vals[k] = SAMPLE_W'(m + d);
                    vals[k+1] = SAMPLE_W'(m - d);
                end
            endcase
        end
        // one code short of the level boundary, so the truncated mean drops a level
        if (pat == PAT_PAIRS_LOW && m > 0) begin
            for (int k = 0; k < BLOCK_LEN; k++) begin
                if (vals[k] != 0) begin
                    vals[k] = vals[k] - 1'b1;
                    break;
                end
            end
        end
        for (int k = 0; k < BLOCK_LEN; k++) begin
            while ($urandom_range(0, 99) < 22)
                drive_item(1'b1, SAMPLE_W'($urandom), no_gap);
            drive_item(1'b0, vals[k], no_gap);
        end
    endtask

    always @(posedge i_clk) begin
        if (regime_left == 0) begin
            case ($urandom_range(0, 2))
                0: stall_pct <= 0;
                1: stall_pct <= 20;
                default: stall_pct <= 60;
            endcase
            regime_left <= $urandom_range(50, 300);
        end else begin
            regime_left <= regime_left - 1;
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left <= pick_gap();
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_word(o_scan_word);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles, sb.pending());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int blk;
        int level;
        t_block_pat pat;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ticks straight after reset: blank rows, every select bit, pointer wrap,
        // with the unused sample field at both extremes
        for (int i = 0; i <= ROW_CNT; i++)
            drive_item(1'b1, (i % 2) ? SAMPLE_W'(0) : '1, 1'b0);
        drive_item(1'b0, '0, 1'b0);
        drive_item(1'b0, '1, 1'b0);
        drive_item(1'b0, 8'h80, 1'b1);
        drive_item(1'b0, 8'h7f, 1'b1);
        drive_item(1'b1, 8'h55, 1'b1);
        drive_item(1'b1, 8'haa, 1'b0);
        drain_words();

        // finish the open block so random blocks start aligned
        while (sb.block_count != 0) drive_item(1'b0, '1, 1'b0);

        blk = 0;
        while (items_sent < ITEM_TARGET) begin
            if (blk < LEVEL_CNT) begin
                level = (blk * 5 + 7) % LEVEL_CNT;
            end else begin
                level = $urandom_range(0, LEVEL_CNT - 1);
            end
            case ($urandom_range(0, 9))
                0, 1:    pat = PAT_CONST;
                2, 3, 4: pat = PAT_PAIRS;
                5, 6:    pat = PAT_PAIRS_LOW;
                default: pat = PAT_NOISE;
            endcase
            if (blk == 0) begin
                level = LEVEL_CNT - 1;
                pat = PAT_CONST;
            end
            run_block(level, pat, $urandom_range(0, 4) == 0);
            // a scan sweep now and then reads the whole scrolled picture
            if ($urandom_range(0, 2) == 0) begin
                for (int i = 0; i < ROW_CNT; i++)
                    drive_item(1'b1, SAMPLE_W'($urandom), 1'b0);
            end
            if ($urandom_range(0, 3) == 0) drain_words();
            blk++;
        end

        drain_words();
        repeat (5) @(posedge i_clk);
        $display("sent %0d items: %0d samples closing %0d blocks, %0d refresh ticks",
                 items_sent, sb.samples_seen, sb.blocks_closed, ticks_sent);
        $display("checked %0d scan words, levels reached %b, %0d errors",
                 sb.words_checked, sb.levels_seen, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
